### rtl/wss_pkg.sv
package wss_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_WAVES_DEF = 4;
   localparam int MAX_BODIES_DEF = 2;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // 2*pi in Q.16.
   localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE, ST_PH_X, ST_PH_Z, ST_PH_T, ST_SIN, ST_COS, ST_SL_X, ST_SL_Z,
      ST_G_X, ST_G_Z, ST_SQ_X, ST_SQ_Z, ST_ROOT, ST_DIV_LOAD, ST_DIV, ST_DONE
   } state_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_WAVE_COUNT = 3'd0, CSR_WAVE_0 = 3'd1, CSR_WAVE_1 = 3'd2,
      CSR_WAVE_2 = 3'd3, CSR_WAVE_3 = 3'd4, CSR_BODY_0 = 3'd5,
      CSR_BODY_1 = 3'd6, CSR_SPARE = 3'd7
   } csr_index_type;

   // One sine table entry in Q1.14, from a quarter-wave odd polynomial in Q2.30.
   function automatic logic signed [15:0] sine_value(int idx, int bits);
      longint qb, quad, r, u, u2, s, v;
      qb = bits - 2;
      quad = (idx >> qb) & 3;
      r = idx & ((64'sd1 << qb) - 1);
      if (quad[0]) r = (64'sd1 << qb) - r;
      u = r << (30 - qb);
      u2 = (u * u) >>> 30;
      s = 64'sd3864;
      s = 64'sd172272 - ((s * u2) >>> 30);
      s = 64'sd5026995 - ((s * u2) >>> 30);
      s = 64'sd85569306 - ((s * u2) >>> 30);
      s = 64'sd693598668 - ((s * u2) >>> 30);
      s = 64'sd1686629713 - ((s * u2) >>> 30);
      s = (s * u) >>> 30;
      v = (s + 64'sd32768) >>> 16;
      if (v > 16384) v = 16384;
      if (quad[1]) v = -v;
      return 16'(v);
   endfunction

endpackage

### rtl/wss_sine_rom.sv
module wss_sine_rom #(
   parameter int SINE_TABLE_BITS = wss_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic [SINE_TABLE_BITS-1:0] addr,
   output logic signed [15:0]         sin_value,
   output logic signed [15:0]         cos_value
);

   localparam int SIZE = 1 << SINE_TABLE_BITS;

   logic signed [15:0] rom [SIZE];
   logic [SINE_TABLE_BITS-1:0] cos_addr;
   logic signed [15:0] sin_ff, cos_ff;

   // Constant table, folded at elaboration.
   always_comb begin
      for (int i = 0; i < SIZE; i++) begin
         rom[i] = wss_pkg::sine_value(i, SINE_TABLE_BITS);
      end
   end

   // The cosine sits a quarter turn ahead.
   assign cos_addr = addr + SINE_TABLE_BITS'(SIZE / 4);

   // Registered read: the values appear in the cycle after the address.
   always_ff @(posedge clock) begin
      sin_ff <= rom[addr];
      cos_ff <= rom[cos_addr];
   end

   assign sin_value = sin_ff;
   assign cos_value = cos_ff;

endmodule

### rtl/wave_surface_sampler_core.sv
// Channel  | Ports                                  | Direction | Handshake
// request  | req_pos_x/y/z, req_sample_time         | in        | start & !busy
// response | rsp_surface_height, rsp_normal_*, ...  | out       | rsp_valid, one cycle
// config   | csr_index, csr_data                    | in        | csr_valid & csr_ready
//
// One beat runs the phase, sine, cosine and slope steps for each enabled wave on
// the shared multiplier, then the gradient and square steps, 31 square-root steps
// and three divisions (load, 16 quotient steps, store), then a final step: busy
// stays high throughout, and the result appears in the cycle in which busy falls.
// Reset clears only the sequencer and the configuration. The receiver cannot stall:
// each result is presented for exactly one cycle. Configuration is always ready.
module wave_surface_sampler_core #(
   parameter int MAX_WAVES = wss_pkg::MAX_WAVES_DEF,
   parameter int MAX_BODIES = wss_pkg::MAX_BODIES_DEF,
   parameter int SINE_TABLE_BITS = wss_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [23:0]  req_pos_x,
   input  logic signed [23:0]  req_pos_y,
   input  logic signed [23:0]  req_pos_z,
   input  logic [31:0]         req_sample_time,
   output logic                rsp_valid,
   output logic signed [23:0]  rsp_surface_height,
   output logic signed [15:0]  rsp_normal_x,
   output logic [14:0]         rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z,
   output logic                rsp_in_water,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data
);

   wss_pkg::state_type state_ff, state_in;

   logic [2:0]  wave_count_ff;
   logic [63:0] wave_ff [4];
   logic [48:0] body_ff [2];

   logic signed [23:0] x_ff, y_ff, z_ff;
   logic [31:0] t_ff;
   logic [1:0]  w_ff, w_in;
   logic [2:0]  n_ff, n_in;
   logic [19:0] ph_ff, ph_in;
   logic signed [35:0] acc_ff, acc_in;
   logic signed [31:0] camp_ff, camp_in;
   logic signed [49:0] sumx_ff, sumx_in, sumz_ff, sumz_in;
   logic signed [31:0] nx_ff, nx_in, nz_ff, nz_in;
   logic [61:0] sq_ff, sq_in, v_ff, v_in;
   logic [33:0] rrem_ff, rrem_in;
   logic [30:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] drem_ff, drem_in;
   logic [15:0] num_ff, num_in, q_ff, q_in;
   logic [1:0]  sel_ff, sel_in;
   logic [15:0] cx_ff, cx_in, cz_ff, cz_in;
   logic [14:0] cy_ff, cy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] h_ff, h_in;
   logic        wet_ff, wet_in;

   logic signed [31:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [64:0] prod;
   logic signed [15:0] sin_v, cos_v;
   logic [63:0] wave_cur;
   logic [15:0] amp;
   logic signed [15:0] kx, kz, om;

   // Base height from the last enabled body that holds the point.
   logic signed [15:0] base;
   logic [23:0] ax, az;
   always_comb begin
      ax = req_pos_x[23] ? 24'(-req_pos_x) : req_pos_x;
      az = req_pos_z[23] ? 24'(-req_pos_z) : req_pos_z;
      base = '0;
      for (int i = 0; i < MAX_BODIES; i++) begin
         if (body_ff[i][0] && ax <= {body_ff[i][16:1], 8'd0}
             && az <= {body_ff[i][32:17], 8'd0}) begin
            base = body_ff[i][48:33];
         end
      end
   end

   // Configuration writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_count_ff <= '0;
         for (int i = 0; i < 4; i++) wave_ff[i] <= '0;
         for (int i = 0; i < 2; i++) body_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (wss_pkg::csr_index_type'(csr_index))
            wss_pkg::CSR_WAVE_COUNT: wave_count_ff <= csr_data[2:0];
            wss_pkg::CSR_WAVE_0:     wave_ff[0] <= csr_data;
            wss_pkg::CSR_WAVE_1:     wave_ff[1] <= csr_data;
            wss_pkg::CSR_WAVE_2:     wave_ff[2] <= csr_data;
            wss_pkg::CSR_WAVE_3:     wave_ff[3] <= csr_data;
            wss_pkg::CSR_BODY_0:     body_ff[0] <= csr_data[48:0];
            wss_pkg::CSR_BODY_1:     body_ff[1] <= csr_data[48:0];
            default: ;
         endcase
      end
   end

   // The table is read with the next phase, so its values are ready in the sine step.
   wss_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
      .clock(clock),
      .addr(ph_in[19 -: SINE_TABLE_BITS]),
      .sin_value(sin_v),
      .cos_value(cos_v)
   );

   assign wave_cur = wave_ff[w_ff];
   assign amp = wave_cur[15:0];
   assign kx = wave_cur[31:16];
   assign kz = wave_cur[47:32];
   assign om = wave_cur[63:48];
   assign prod = mul_a * mul_b;

   // Helper values for the slope, root and division steps.
   logic signed [35:0] fsh;
   logic signed [32:0] fsat;
   logic signed [48:0] gsh;
   logic signed [31:0] gcl;
   logic [33:0] rcur, rtrial;
   logic signed [31:0] csel;
   logic [30:0] cmag;
   logic [44:0] dnum;
   logic [32:0] dcur;
   logic [15:0] qcl;
   logic [1:0]  ncl;
   logic signed [37:0] hround;

   always_comb begin
      // Wave count limited to the configured maximum.
      ncl = (wave_count_ff > 3'(MAX_WAVES)) ? 2'(MAX_WAVES - 1) : 2'(wave_count_ff - 3'd1);
      fsh = (state_ff == wss_pkg::ST_G_X) ? 36'(sumx_ff >>> 14) : 36'(sumz_ff >>> 14);
      if (fsh > 36'sd536870912) fsat = 33'sd536870912;
      else if (fsh < -36'sd536870912) fsat = -33'sd536870912;
      else fsat = 33'(fsh);
      gsh = 49'(prod >>> 16);
      if (gsh > 49'sd1073741824) gcl = 32'sd1073741824;
      else if (gsh < -49'sd1073741824) gcl = -32'sd1073741824;
      else gcl = 32'(gsh);
      rcur = {rrem_ff[31:0], v_ff[61:60]};
      rtrial = {1'b0, root_ff, 2'b01};
      unique case (sel_ff)
         2'd0: csel = nx_ff;
         2'd1: csel = 32'sd1048576;
         default: csel = nz_ff;
      endcase
      cmag = csel[31] ? 31'(-csel) : 31'(csel);
      dnum = {cmag, 14'd0} + 45'(root_ff >> 1);
      dcur = {drem_ff, num_ff[15]};
      qcl = (q_ff > 16'd16384) ? 16'd16384 : q_ff;
      hround = 38'(acc_ff) + 38'sd8192;
   end

   // Rounded height. The accumulator range keeps it well inside 24 bits,
   // so taking bits 37:14 needs no saturation.
   logic signed [23:0] h_done;
   assign h_done = hround[37:14];

   // Sequencer and the shared multiplier.
   always_comb begin
      state_in = state_ff;
      mul_a = '0;
      mul_b = '0;
      w_in = w_ff; n_in = n_ff; ph_in = ph_ff; acc_in = acc_ff; camp_in = camp_ff;
      sumx_in = sumx_ff; sumz_in = sumz_ff; nx_in = nx_ff; nz_in = nz_ff;
      sq_in = sq_ff; v_in = v_ff; rrem_in = rrem_ff; root_in = root_ff; cnt_in = cnt_ff;
      drem_in = drem_ff; num_in = num_ff; q_in = q_ff; sel_in = sel_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      rsp_valid_in = 1'b0; h_in = h_ff; wet_in = wet_ff;
      unique case (state_ff)
         wss_pkg::ST_IDLE: begin
            if (start) begin
               acc_in = 36'(base) <<< 14;
               sumx_in = '0;
               sumz_in = '0;
               w_in = '0;
               n_in = {1'b0, ncl};
               state_in = (wave_count_ff == 3'd0) ? wss_pkg::ST_G_X : wss_pkg::ST_PH_X;
            end
         end
         wss_pkg::ST_PH_X: begin
            mul_a = 32'(kx); mul_b = 33'(x_ff);
            ph_in = prod[19:0];
            state_in = wss_pkg::ST_PH_Z;
         end
         wss_pkg::ST_PH_Z: begin
            mul_a = 32'(kz); mul_b = 33'(z_ff);
            ph_in = ph_ff + prod[19:0];
            state_in = wss_pkg::ST_PH_T;
         end
         wss_pkg::ST_PH_T: begin
            mul_a = 32'(om); mul_b = {1'b0, t_ff};
            ph_in = ph_ff - prod[27:8];
            state_in = wss_pkg::ST_SIN;
         end
         wss_pkg::ST_SIN: begin
            mul_a = {16'd0, amp}; mul_b = 33'(sin_v);
            acc_in = acc_ff + 36'(prod);
            state_in = wss_pkg::ST_COS;
         end
         wss_pkg::ST_COS: begin
            mul_a = {16'd0, amp}; mul_b = 33'(cos_v);
            camp_in = prod[31:0];
            state_in = wss_pkg::ST_SL_X;
         end
         wss_pkg::ST_SL_X: begin
            mul_a = 32'(kx); mul_b = 33'(camp_ff);
            sumx_in = sumx_ff + 50'(prod);
            state_in = wss_pkg::ST_SL_Z;
         end
         wss_pkg::ST_SL_Z: begin
            mul_a = 32'(kz); mul_b = 33'(camp_ff);
            sumz_in = sumz_ff + 50'(prod);
            w_in = w_ff + 2'd1;
            state_in = (3'(w_ff) == n_ff) ? wss_pkg::ST_G_X : wss_pkg::ST_PH_X;
         end
         wss_pkg::ST_G_X: begin
            mul_a = wss_pkg::TWO_PI_Q16; mul_b = fsat;
            nx_in = -gcl;
            state_in = wss_pkg::ST_G_Z;
         end
         wss_pkg::ST_G_Z: begin
            mul_a = wss_pkg::TWO_PI_Q16; mul_b = fsat;
            nz_in = -gcl;
            state_in = wss_pkg::ST_SQ_X;
         end
         wss_pkg::ST_SQ_X: begin
            mul_a = nx_ff; mul_b = 33'(nx_ff);
            sq_in = prod[61:0];
            state_in = wss_pkg::ST_SQ_Z;
         end
         wss_pkg::ST_SQ_Z: begin
            mul_a = nz_ff; mul_b = 33'(nz_ff);
            v_in = sq_ff + prod[61:0] + (62'd1 << 40);
            rrem_in = '0;
            root_in = '0;
            cnt_in = 5'd30;
            state_in = wss_pkg::ST_ROOT;
         end
         wss_pkg::ST_ROOT: begin
            // Two bits of the radicand per step.
            v_in = v_ff << 2;
            if (rcur >= rtrial) begin
               rrem_in = rcur - rtrial;
               root_in = {root_ff[29:0], 1'b1};
            end else begin
               rrem_in = rcur;
               root_in = {root_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               sel_in = 2'd0;
               state_in = wss_pkg::ST_DIV_LOAD;
            end
         end
         wss_pkg::ST_DIV_LOAD: begin
            drem_in = 32'(dnum[44:16]);
            num_in = dnum[15:0];
            q_in = '0;
            cnt_in = 5'd15;
            state_in = wss_pkg::ST_DIV;
         end
         wss_pkg::ST_DIV: begin
            if (cnt_ff == 5'd31) begin
               // Quotient complete: store the component and move on.
               unique case (sel_ff)
                  2'd0: cx_in = csel[31] ? -qcl : qcl;
                  2'd1: cy_in = qcl[14:0];
                  default: cz_in = csel[31] ? -qcl : qcl;
               endcase
               sel_in = sel_ff + 2'd1;
               state_in = (sel_ff == 2'd2) ? wss_pkg::ST_DONE : wss_pkg::ST_DIV_LOAD;
            end else begin
               // One quotient bit per step; the root is the divisor.
               num_in = num_ff << 1;
               if (dcur >= {2'b00, root_ff}) begin
                  drem_in = 32'(dcur - {2'b00, root_ff});
                  q_in = {q_ff[14:0], 1'b1};
               end else begin
                  drem_in = dcur[31:0];
                  q_in = {q_ff[14:0], 1'b0};
               end
               cnt_in = (cnt_ff == 5'd0) ? 5'd31 : cnt_ff - 5'd1;
            end
         end
         wss_pkg::ST_DONE: begin
            h_in = h_done;
            wet_in = (y_ff <= h_done);
            rsp_valid_in = 1'b1;
            state_in = wss_pkg::ST_IDLE;
         end
         default: state_in = wss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == wss_pkg::ST_IDLE && start) begin
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
         z_ff <= req_pos_z;
         t_ff <= req_sample_time;
      end
      w_ff <= w_in; n_ff <= n_in; ph_ff <= ph_in; acc_ff <= acc_in; camp_ff <= camp_in;
      sumx_ff <= sumx_in; sumz_ff <= sumz_in; nx_ff <= nx_in; nz_ff <= nz_in;
      sq_ff <= sq_in; v_ff <= v_in; rrem_ff <= rrem_in; root_ff <= root_in;
      drem_ff <= drem_in; num_ff <= num_in; q_ff <= q_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      h_ff <= h_in;
      wet_ff <= wet_in;
   end

   // Counters and selectors are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sel_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
      end
   end

   assign busy = (state_ff != wss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_surface_height = h_ff;
   assign rsp_normal_x = cx_ff;
   assign rsp_normal_y = cy_ff;
   assign rsp_normal_z = cz_ff;
   assign rsp_in_water = wet_ff;

endmodule

### bench/tb_wave_surface_sampler_core.sv
// One predicted or observed sample of the water surface.
typedef struct packed {
   logic signed [23:0] height;
   logic signed [15:0] norm_x;
   logic [14:0]        norm_y;
   logic signed [15:0] norm_z;
   logic               wet;
} surface_sample_type;

// Holds its own copy of the registers, predicts each accepted beat and checks results.
class surface_scoreboard;
   localparam int TABLE_BITS = 10;
   localparam int WAVE_LIMIT = 4;
   localparam longint SLOPE_MAX = 64'sd1 << 30;
   localparam longint ONE_Q20 = 64'sd1 << 20;

   logic [2:0]  wave_count;
   logic [63:0] wave_reg[4];
   logic [48:0] body_reg[2];
   surface_sample_type expected_samples[$];
   int errors;
   int samples_checked;

   function new();
      wave_count = '0;
      foreach (wave_reg[i]) wave_reg[i] = '0;
      foreach (body_reg[i]) body_reg[i] = '0;
      errors = 0;
      samples_checked = 0;
   endfunction

   function void write_register(wss_pkg::csr_index_type idx, logic [63:0] data);
      case (idx)
         wss_pkg::CSR_WAVE_COUNT: wave_count = data[2:0];
         wss_pkg::CSR_WAVE_0, wss_pkg::CSR_WAVE_1, wss_pkg::CSR_WAVE_2,
         wss_pkg::CSR_WAVE_3: wave_reg[int'(idx) - 1] = data;
         wss_pkg::CSR_BODY_0, wss_pkg::CSR_BODY_1: body_reg[int'(idx) - 5] = data[48:0];
         default: ;
      endcase
   endfunction

   // Quarter-wave odd polynomial in Q2.30, rounded to Q1.14.
   function longint table_sine(longint idx);
      longint quad, r, u, u2, s, v;
      idx = idx & ((64'sd1 << TABLE_BITS) - 1);
      quad = idx >> (TABLE_BITS - 2);
      r = idx & ((64'sd1 << (TABLE_BITS - 2)) - 1);
      if (quad & 1) r = (64'sd1 << (TABLE_BITS - 2)) - r;
      u = r << (30 - (TABLE_BITS - 2));
      u2 = (u * u) >>> 30;
      s = 3864;
      s = 172272 - ((s * u2) >>> 30);
      s = 5026995 - ((s * u2) >>> 30);
      s = 85569306 - ((s * u2) >>> 30);
      s = 693598668 - ((s * u2) >>> 30);
      s = 1686629713 - ((s * u2) >>> 30);
      s = (s * u) >>> 30;
      v = (s + 32768) >>> 16;
      if (v > 16384) v = 16384;
      return (quad & 2) ? -v : v;
   endfunction

   function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function longint unit_component(longint c, longint unsigned len);
      longint unsigned m, q;
      m = longint'(c < 0 ? -c : c) * 16384;
      q = (m + len / 2) / len;
      if (q > 16384) q = 16384;
      return c < 0 ? -longint'(q) : longint'(q);
   endfunction

   function longint clamp_slope(longint g);
      if (g > SLOPE_MAX) return SLOPE_MAX;
      if (g < -SLOPE_MAX) return -SLOPE_MAX;
      return g;
   endfunction

   // Predict the result of one accepted beat and queue it.
   function void note_sample(logic signed [23:0] px, logic signed [23:0] py,
                             logic signed [23:0] pz, logic [31:0] st);
      longint x, y, z, t, ax, az, base, acc, h, sumx, sumz, gx, gz, nx, nz;
      longint amp, kx, kz, om, ph, s, c;
      longint unsigned len;
      int n;
      surface_sample_type p;
      x = px; y = py; z = pz; t = longint'(st);
      ax = x < 0 ? -x : x;
      az = z < 0 ? -z : z;
      base = 0;
      sumx = 0;
      sumz = 0;
      // The later enabled body wins where both boxes hold the point.
      for (int i = 0; i < 2; i++) begin
         if (body_reg[i][0] && ax <= longint'(body_reg[i][16:1]) * 256 &&
             az <= longint'(body_reg[i][32:17]) * 256)
            base = longint'($signed(body_reg[i][48:33]));
      end
      acc = base * 16384;
      n = (wave_count > WAVE_LIMIT) ? WAVE_LIMIT : int'(wave_count);
      for (int i = 0; i < n; i++) begin
         amp = longint'(wave_reg[i][15:0]);
         kx = longint'($signed(wave_reg[i][31:16]));
         kz = longint'($signed(wave_reg[i][47:32]));
         om = longint'($signed(wave_reg[i][63:48]));
         ph = (kx * x + kz * z - ((om * t) >>> 8)) & 64'hFFFFF;
         s = table_sine(ph >> (20 - TABLE_BITS));
         c = table_sine((ph >> (20 - TABLE_BITS)) + (64'sd1 << (TABLE_BITS - 2)));
         acc += amp * s;
         sumx += amp * kx * c;
         sumz += amp * kz * c;
      end
      h = (acc + 8192) >>> 14;
      if (h > 8388607) h = 8388607;
      if (h < -8388608) h = -8388608;
      gx = ((sumx >>> 14) * longint'(wss_pkg::TWO_PI_Q16)) >>> 16;
      gz = ((sumz >>> 14) * longint'(wss_pkg::TWO_PI_Q16)) >>> 16;
      nx = -clamp_slope(gx);
      nz = -clamp_slope(gz);
      len = root_floor(longint'(nx * nx) + longint'(nz * nz) + ONE_Q20 * ONE_Q20);
      p.height = h[23:0];
      p.norm_x = 16'(unit_component(nx, len));
      p.norm_y = 15'(unit_component(ONE_Q20, len));
      p.norm_z = 16'(unit_component(nz, len));
      p.wet = (y <= h);
      expected_samples.insert(expected_samples.size(), p);
   endfunction

   function void compare_field(string field, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   function void check_sample(surface_sample_type got);
      surface_sample_type want;
      if (expected_samples.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none actual height %0d",
                  $time, got.height);
         return;
      end
      want = expected_samples.pop_front();
      samples_checked++;
      compare_field("surface_height", want.height, got.height);
      compare_field("normal_x", want.norm_x, got.norm_x);
      compare_field("normal_y", want.norm_y, got.norm_y);
      compare_field("normal_z", want.norm_z, got.norm_z);
      compare_field("in_water", want.wet, got.wet);
   endfunction
endclass

module tb_wave_surface_sampler_core;
   localparam int STALL_LIMIT = 2000;

   logic clock, reset, start, busy;
   logic signed [23:0] req_pos_x, req_pos_y, req_pos_z;
   logic [31:0] req_sample_time;
   logic rsp_valid;
   logic signed [23:0] rsp_surface_height;
   logic signed [15:0] rsp_normal_x, rsp_normal_z;
   logic [14:0] rsp_normal_y;
   logic rsp_in_water;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [63:0] csr_data;

   surface_scoreboard sb = new();
   int quiet_cycles;
   int beats_sent;
   int csr_writes;
   bit idling_on;

   wave_surface_sampler_core uut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Check every result on the cycle it is presented.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_sample('{rsp_surface_height, rsp_normal_x, rsp_normal_y,
                           rsp_normal_z, rsp_in_water});
   end

   // Watchdog: cycles with no beat on any channel.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d quiet cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // Sender gap: a random burst of idle cycles now and then.
   task automatic maybe_pause();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Present one beat and hold it until the block takes it.
   task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             logic [31:0] st);
      maybe_pause();
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_sample_time <= st;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_sample(req_pos_x, req_pos_y, req_pos_z, req_sample_time);
      beats_sent++;
   endtask

   task automatic write_csr(wss_pkg::csr_index_type idx, logic [63:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      csr_writes++;
   endtask

   // Drain all pending results before touching the registers.
   task automatic wait_drained();
      start <= 1'b0;
      csr_valid <= 1'b0;
      while (sb.expected_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_all(logic [2:0] cnt, logic [63:0] w0, logic [63:0] w1,
                            logic [63:0] w2, logic [63:0] w3,
                            logic [48:0] b0, logic [48:0] b1);
      write_csr(wss_pkg::CSR_WAVE_COUNT, {61'd0, cnt});
      write_csr(wss_pkg::CSR_WAVE_0, w0);
      write_csr(wss_pkg::CSR_WAVE_1, w1);
      write_csr(wss_pkg::CSR_WAVE_2, w2);
      write_csr(wss_pkg::CSR_WAVE_3, w3);
      write_csr(wss_pkg::CSR_BODY_0, {15'd0, b0});
      write_csr(wss_pkg::CSR_BODY_1, {15'd0, b1});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [48:0] random_body();
      logic [15:0] ex, ez;
      ex = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      ez = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      return {16'($urandom), ez, ex, 1'($urandom_range(0, 4) != 0)};
   endfunction

   // Positions mostly near the body boxes, the rest anywhere.
   function automatic logic [23:0] random_coord();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 24000)) - 12000);
         2: return 24'($signed($urandom_range(0, 512)) - 256);
         default: return 24'($signed($urandom_range(0, 2 * 10240)) - 10240);
      endcase
   endfunction

   task automatic send_directed();
      send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFFFFFF);
      send_point(24'h800000, 24'h800000, 24'h800000, 32'h0);
      send_point(24'h0, 24'h0, 24'h0, 32'h0);
      send_point(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 32'h00010000);
      send_point(24'h000100, 24'hFFFF00, 24'hFFFF00, 32'h80000000);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = wss_pkg::CSR_WAVE_COUNT;
      csr_data = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_sample_time = '0;
      beats_sent = 0;
      csr_writes = 0;
      idling_on = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: registers at reset, then all ones, then steep waves and nested bodies.
      send_directed();
      wait_drained();
      write_all(3'd7, '1, '1, '1, '1, '1, '1);
      send_directed();
      wait_drained();
      write_all(3'd4, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h8000, 16'h0100}, 64'h0, 64'h1234_0800_0400_0080,
                {16'h7FFF, 16'd10, 16'd10, 1'b1}, {16'h8000, 16'd2, 16'd2, 1'b1});
      send_directed();
      send_point(24'h000A00, 24'h0, 24'h000A00, 32'h1234);
      send_point(24'h000200, 24'h0, 24'hFFFE00, 32'h5678);
      send_point(24'h000A01, 24'h0, 24'h0, 32'h9ABC);
      wait_drained();
      // An unused index must leave everything alone.
      write_csr(wss_pkg::CSR_SPARE, '1);
      write_all(3'd1, 64'h0000_0000_0000_0100, 64'h0, 64'h0, 64'h0, 49'h0, 49'h0);
      send_point(24'h0, 24'h000100, 24'h0, 32'h0);
      send_point(24'h0, 24'hFFFF00, 24'h0, 32'h00004000);
      wait_drained();

      // Random phases, each with its own register setting; the last runs without gaps.
      for (int ph = 0; ph < 9; ph++) begin
         write_all(3'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, random_body(),
                   random_body());
         if (ph == 8) idling_on = 1'b0;
         for (int i = 0; i < 175; i++)
            send_point(random_coord(), 24'($urandom), random_coord(), $urandom);
         wait_drained();
      end
      repeat (150) @(posedge clock);

      $display("Sent %0d sample beats over 13 register settings (%0d register writes),",
               beats_sent, csr_writes);
      $display("checked %0d results against the predicted surface.", sb.samples_checked);
      if (sb.errors == 0 && sb.expected_samples.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

### wave_surface_sampler_core.f
rtl/wss_pkg.sv
rtl/wss_sine_rom.sv
rtl/wave_surface_sampler_core.sv
bench/tb_wave_surface_sampler_core.sv
